/* hdl/dslb_pkg.sv */
// Shared types and constants for the decompression and low-bit sampling block.
package dslb_pkg;

  // Field widths
  localparam int unsigned T_W     = 9;   // compressed coefficient
  localparam int unsigned CHUNK_W = 40;  // random chunk
  localparam int unsigned VALUE_W = 12;  // stored coefficient
  localparam int unsigned COEF_W  = 13;  // emitted coefficient, two's complement
  localparam int unsigned IDX_W   = 8;   // emitted index

  // Candidate unpacking and acceptance
  localparam int unsigned CAND_W        = 5;
  localparam int unsigned CANDS         = 8;
  localparam int unsigned SPECIAL_LIMIT = 22;
  localparam int unsigned NORMAL_LIMIT  = 21;
  localparam int unsigned SPECIAL_BIAS  = 11;
  localparam int unsigned NORMAL_BIAS   = 10;

  // Decompression rounding
  localparam int unsigned ROUND_HALF = 256;
  localparam int unsigned T_SHIFT    = 9;
  localparam int unsigned PROD_W     = 22;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Item kinds
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // One classified command: a decompressed value in the low bits, or a chunk
  typedef struct packed {
    logic               op;
    logic [CHUNK_W-1:0] arg;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* hdl/decompress_with_sampled_low_bits.sv */
// Top level: decompression of coefficients with sampled low-bit adjustment.
//
//   channel   direction  tdata (low bit up)                           tuser    tlast
//   s_axis    in         compressed_value[8:0], random_chunk[48:9]    opcode   -
//   m_axis    out        coefficient[12:0], coeff_index[20:13]        -        last
//
// A load passes through the front stage and the command queue, and the back end then
// writes it to the coefficient store. A sample chunk is dequeued and its candidates
// are evaluated in turn; the coefficient store, with its single read port, is read
// anew before each candidate that follows a finished coefficient. A chunk that runs
// out of loaded coefficients ends early when nothing is left to apply. A stalled m_axis
// holds the back end at the next result; the front stage and queue keep taking
// transactions until both the queue and the front stage are full.
// Reset clears the counters and control state; the store needs no clearing.
module decompress_with_sampled_low_bits #(
  parameter int unsigned COEFFS  = 256,
  parameter int unsigned MODULUS = 3329
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // compressed_value[8:0], random_chunk[48:9], zeros
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // coefficient[12:0], coeff_index[20:13], zeros
  output logic        m_axis_tlast
);

  dslb_pkg::queue_stat_t          stat;
  dslb_pkg::cmd_t                 push_cmd;
  dslb_pkg::cmd_t                 head;
  logic                           push, pop;
  logic [dslb_pkg::COEF_W-1:0]    coef;
  logic [dslb_pkg::IDX_W-1:0]     idx;

  dslb_front #(
    .MODULUS (MODULUS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .t_i        (s_axis_tdata[8:0]),
    .chunk_i    (s_axis_tdata[48:9]),
    .stat_i     (stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  dslb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  dslb_back #(
    .COEFFS  (COEFFS),
    .MODULUS (MODULUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_coef_o  (coef),
    .out_idx_o   (idx),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, idx, coef};

  // The final coefficient carries the last index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> idx == dslb_pkg::IDX_W'(COEFFS - 1))
    else $error("tlast on a coefficient other than the final one");

  // The front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stat.full)
    else $error("command pushed into a full queue");

  // The back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty)
    else $error("command popped from an empty queue");

endmodule

/* hdl/dslb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dslb_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/dslb_front.sv */
// Front end: accept input transactions, classify them and decompress loads.
module dslb_front #(
  parameter int unsigned MODULUS = 3329
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [dslb_pkg::T_W-1:0]      t_i,
  input  logic [dslb_pkg::CHUNK_W-1:0]  chunk_i,
  input  dslb_pkg::queue_stat_t         stat_i,
  output logic                          push_o,
  output dslb_pkg::cmd_t                cmd_o
);

  logic                          stage_valid_q, stage_valid_d;
  dslb_pkg::cmd_t                stage_q, stage_d;
  logic                          accept;
  logic [dslb_pkg::PROD_W-1:0]   prod;
  logic [dslb_pkg::VALUE_W-1:0]  value;

  // Decompress: (t*MODULUS + 256) >> 9, kept to the stored width
  assign prod  = dslb_pkg::PROD_W'(t_i) * dslb_pkg::PROD_W'(MODULUS)
               + dslb_pkg::PROD_W'(dslb_pkg::ROUND_HALF);
  assign value = prod[dslb_pkg::T_SHIFT +: dslb_pkg::VALUE_W];

  // Hand the staged command to the queue when there is room
  assign push_o     = stage_valid_q && !stat_i.full;
  assign in_ready_o = !stage_valid_q || !stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign cmd_o      = stage_q;

  // Build the next staged command
  always_comb begin
    stage_valid_d = stage_valid_q;
    stage_d       = stage_q;
    if (push_o) begin
      stage_valid_d = 1'b0;
    end
    if (accept) begin
      stage_valid_d = 1'b1;
      stage_d.op    = op_i;
      if (op_i == dslb_pkg::OP_SAMPLE) begin
        stage_d.arg = chunk_i;
      end else begin
        stage_d.arg = dslb_pkg::CHUNK_W'(value);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

endmodule

/* hdl/dslb_queue.sv */
// Short command queue between the front end and the back end.
module dslb_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dslb_pkg::cmd_t        cmd_i,
  input  logic                  pop_i,
  output dslb_pkg::cmd_t        head_o,
  output dslb_pkg::queue_stat_t stat_o
);

  localparam int unsigned PW = (dslb_pkg::QUEUE_DEPTH > 1) ? $clog2(dslb_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(dslb_pkg::QUEUE_DEPTH + 1);

  dslb_pkg::cmd_t  mem_q [dslb_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == NW'(dslb_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(dslb_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(dslb_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

/* hdl/dslb_back.sv */
// Back end: store coefficients, apply candidates and drive the result register.
module dslb_back #(
  parameter int unsigned COEFFS  = 256,
  parameter int unsigned MODULUS = 3329
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dslb_pkg::queue_stat_t         stat_i,
  input  dslb_pkg::cmd_t                head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dslb_pkg::COEF_W-1:0]   out_coef_o,
  output logic [dslb_pkg::IDX_W-1:0]    out_idx_o,
  output logic                          out_last_o
);

  localparam int unsigned AW  = $clog2(COEFFS);
  localparam int unsigned CW  = $clog2(COEFFS + 1);
  localparam int unsigned KW  = $clog2(dslb_pkg::CANDS);
  localparam int unsigned RW  = dslb_pkg::COEF_W + 1;
  localparam int unsigned MID = (256 * MODULUS + dslb_pkg::ROUND_HALF) >> dslb_pkg::T_SHIFT;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [CW-1:0]                   lcnt_q, lcnt_d;
  logic [CW-1:0]                   scnt_q, scnt_d;
  logic [KW-1:0]                   k_q, k_d;
  logic [dslb_pkg::CHUNK_W-1:0]    chunk_q, chunk_d;
  logic                            out_valid_q, out_valid_d;
  logic [dslb_pkg::COEF_W-1:0]     out_coef_q;
  logic [dslb_pkg::IDX_W-1:0]      out_idx_q;
  logic                            out_last_q;
  logic                            load_out;

  logic                            we;
  logic [AW-1:0]                   waddr;
  logic [dslb_pkg::VALUE_W-1:0]    rdata;

  logic [dslb_pkg::CAND_W-1:0]     cand;
  logic                            avail, hit_special, hit_normal, hit, out_free;
  logic [RW-1:0]                   adj;
  logic [RW-1:0]                   res;
  logic [CW+dslb_pkg::IDX_W-1:0]   idx_ext;
  logic [CW:0]                     scnt_next;

  dslb_ram #(
    .WIDTH (dslb_pkg::VALUE_W),
    .DEPTH (COEFFS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (head_i.arg[dslb_pkg::VALUE_W-1:0]),
    .raddr_i (scnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Evaluate the current candidate against the current coefficient
  assign cand        = chunk_q[dslb_pkg::CAND_W-1:0];
  assign avail       = (scnt_q < lcnt_q) && (scnt_q < CW'(COEFFS));
  assign hit_special = (rdata == dslb_pkg::VALUE_W'(MID))
                    && (cand < dslb_pkg::CAND_W'(dslb_pkg::SPECIAL_LIMIT));
  assign hit_normal  = (cand < dslb_pkg::CAND_W'(dslb_pkg::NORMAL_LIMIT));
  assign hit         = hit_special || hit_normal;
  assign adj         = hit_special ? RW'(dslb_pkg::SPECIAL_BIAS) : RW'(dslb_pkg::NORMAL_BIAS);
  assign res         = RW'(rdata) + adj - RW'(cand);
  assign idx_ext     = {{dslb_pkg::IDX_W{1'b0}}, scnt_q};
  assign scnt_next   = {1'b0, scnt_q} + (CW + 1)'(1);
  assign out_free    = !out_valid_q || out_ready_i;

  // Sequence loads and candidate steps
  always_comb begin
    state_d     = state_q;
    lcnt_d      = lcnt_q;
    scnt_d      = scnt_q;
    k_d         = k_q;
    chunk_d     = chunk_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o = 1'b1;
          if (head_i.op == dslb_pkg::OP_SAMPLE) begin
            chunk_d = head_i.arg;
            k_d     = '0;
            state_d = ST_FETCH;
          end else begin
            we = 1'b1;
            if (lcnt_q >= CW'(COEFFS)) begin
              // Full polynomial: start a new one at slot 0
              waddr  = '0;
              lcnt_d = CW'(1);
              scnt_d = '0;
            end else begin
              waddr  = lcnt_q[AW-1:0];
              lcnt_d = lcnt_q + CW'(1);
            end
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (!avail) begin
          // Nothing left to apply: drop the rest of the chunk
          state_d = ST_IDLE;
        end else if (hit) begin
          if (out_free) begin
            load_out = 1'b1;
            scnt_d   = scnt_q + CW'(1);
            k_d      = k_q + KW'(1);
            chunk_d  = chunk_q >> dslb_pkg::CAND_W;
            state_d  = (k_q == KW'(dslb_pkg::CANDS - 1)) ? ST_IDLE : ST_FETCH;
          end
        end else begin
          k_d     = k_q + KW'(1);
          chunk_d = chunk_q >> dslb_pkg::CAND_W;
          if (k_q == KW'(dslb_pkg::CANDS - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lcnt_q      <= '0;
      scnt_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcnt_q      <= lcnt_d;
      scnt_q      <= scnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chunk_q <= chunk_d;
    if (load_out) begin
      out_coef_q <= res[dslb_pkg::COEF_W-1:0];
      out_idx_q  <= idx_ext[dslb_pkg::IDX_W-1:0];
      out_last_q <= (scnt_next == (CW + 1)'(COEFFS));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_coef_o  = out_coef_q;
  assign out_idx_o   = out_idx_q;
  assign out_last_o  = out_last_q;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the coefficient decompression and low-bit sampling block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COEFFS    = 256;
  localparam int unsigned MODULUS   = 3329;
  localparam int unsigned MID_COEF  = (256 * MODULUS + dslb_pkg::ROUND_HALF)
                                      >> dslb_pkg::T_SHIFT;
  localparam int unsigned MAX_CYCLE = 300000;
  localparam int unsigned DRAIN_CYC = 60;
  localparam int unsigned LONG_HOLD = 400;

  // One emitted coefficient
  typedef struct packed {
    logic signed [dslb_pkg::COEF_W-1:0] coef;
    logic [dslb_pkg::IDX_W-1:0]         idx;
    logic                               last;
  } coef_result_t;

  // One row of the directed table; a known row carries its first coefficient
  typedef struct {
    logic                         op;
    logic [dslb_pkg::T_W-1:0]     t;
    logic [dslb_pkg::CHUNK_W-1:0] chunk;
    bit                           known;
    int                           coef;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // compressed_value[8:0], random_chunk[48:9], zeros
  logic        s_axis_tuser;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // coefficient[12:0], coeff_index[20:13], zeros
  logic        m_axis_tlast;

  // Predictor state: one polynomial
  logic [dslb_pkg::VALUE_W-1:0] poly_store [COEFFS];
  int unsigned                  loaded_n;
  int unsigned                  finished_n;

  coef_result_t pending_coeffs[$];
  dir_row_t     dir_rows[$];
  int unsigned  mismatch_cnt;
  int unsigned  results_seen;
  int unsigned  cycle_cnt;
  int unsigned  burst_left;
  int           predicted_n;

  decompress_with_sampled_low_bits #(
    .COEFFS (COEFFS),
    .MODULUS(MODULUS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Pack eight 5-bit candidates, first candidate in the low bits
  function automatic logic [dslb_pkg::CHUNK_W-1:0] pack_cands(
    input int v0, input int v1, input int v2, input int v3,
    input int v4, input int v5, input int v6, input int v7);
    logic [dslb_pkg::CHUNK_W-1:0] chunk;
    chunk = {dslb_pkg::CAND_W'(v7), dslb_pkg::CAND_W'(v6),
             dslb_pkg::CAND_W'(v5), dslb_pkg::CAND_W'(v4),
             dslb_pkg::CAND_W'(v3), dslb_pkg::CAND_W'(v2),
             dslb_pkg::CAND_W'(v1), dslb_pkg::CAND_W'(v0)};
    return chunk;
  endfunction

  // Advance the polynomial state by one transaction and queue the coefficients it finishes
  task automatic predict_coeffs(input logic op, input logic [dslb_pkg::T_W-1:0] t,
                                input logic [dslb_pkg::CHUNK_W-1:0] chunk);
    int unsigned  tv;
    int           v;
    int           c;
    int           r;
    bit           ok;
    coef_result_t res;
    if (op == dslb_pkg::OP_LOAD) begin
      // a load into a full polynomial starts a new one
      if (loaded_n >= COEFFS) begin
        loaded_n   = 0;
        finished_n = 0;
      end
      tv = t;
      poly_store[loaded_n] = dslb_pkg::VALUE_W'((tv * MODULUS + dslb_pkg::ROUND_HALF)
                                                >> dslb_pkg::T_SHIFT);
      loaded_n++;
    end else begin
      for (int k = 0; k < dslb_pkg::CANDS; k++) begin
        v = int'(chunk[k*dslb_pkg::CAND_W +: dslb_pkg::CAND_W]);
        // drop candidates with nothing loaded to work on, or a finished polynomial
        if (finished_n >= loaded_n || finished_n >= COEFFS) continue;
        c  = int'(poly_store[finished_n]);
        ok = 1'b1;
        if (c == int'(MID_COEF) && v < int'(dslb_pkg::SPECIAL_LIMIT))
          r = c - (v - int'(dslb_pkg::SPECIAL_BIAS));
        else if (v < int'(dslb_pkg::NORMAL_LIMIT))
          r = c - (v - int'(dslb_pkg::NORMAL_BIAS));
        else ok = 1'b0;
        if (!ok) continue;
        res.coef = r[dslb_pkg::COEF_W-1:0];
        res.idx  = finished_n[dslb_pkg::IDX_W-1:0];
        res.last = (finished_n + 1 == COEFFS);
        pending_coeffs.push_back(res);
        predicted_n++;
        finished_n++;
      end
    end
  endtask

  // Offer one transaction, in bursts separated by random gaps, and predict it on acceptance
  task automatic send_item(input logic op, input logic [dslb_pkg::T_W-1:0] t,
                           input logic [dslb_pkg::CHUNK_W-1:0] chunk);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tdata  = {7'd0, chunk, t};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_coeffs(op, t, chunk);
    @(negedge clk_i);
  endtask

  function automatic logic [dslb_pkg::CHUNK_W-1:0] rand_chunk();
    return dslb_pkg::CHUNK_W'({$urandom, $urandom});
  endfunction

  // Compressed value biased toward the midpoint and the extremes
  function automatic logic [dslb_pkg::T_W-1:0] rand_t();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) return dslb_pkg::T_W'(256);
    if (sel < 24) return '0;
    if (sel < 28) return '1;
    return dslb_pkg::T_W'($urandom_range(0, 511));
  endfunction

  // Add a directed row
  task automatic add_row(input logic op, input int t,
                         input logic [dslb_pkg::CHUNK_W-1:0] chunk,
                         input bit known, input int coef);
    dir_row_t row;
    row.op    = op;
    row.t     = dslb_pkg::T_W'(t);
    row.chunk = chunk;
    row.known = known;
    row.coef  = coef;
    dir_rows.push_back(row);
  endtask

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    coef_result_t got;
    coef_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.coef = m_axis_tdata[dslb_pkg::COEF_W-1:0];
      got.idx  = m_axis_tdata[dslb_pkg::COEF_W +: dslb_pkg::IDX_W];
      got.last = m_axis_tlast;
      results_seen++;
      if (pending_coeffs.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected coefficient %0d at index %0d", $time, got.coef, got.idx);
      end else begin
        want = pending_coeffs.pop_front();
        if (got.coef !== want.coef) begin
          mismatch_cnt++;
          $display("%0t: coefficient expected %0d actual %0d", $time, want.coef, got.coef);
        end
        if (got.idx !== want.idx) begin
          mismatch_cnt++;
          $display("%0t: index expected %0d actual %0d", $time, want.idx, got.idx);
        end
        if (got.last !== want.last) begin
          mismatch_cnt++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        end
      end
    end
  end

  // Receiver: stall on changing patterns, with one long hold-off to back up the block
  initial begin
    int  mode;
    int  mode_left;
    int  hold_left;
    bit  held;
    m_axis_tready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 120) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 64);
        end
        mode_left--;
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = 1'($urandom_range(0, 1));
          default: m_axis_tready = (mode_left % 4 == 0);
        endcase
      end
    end
  end

  // Cycle limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < MAX_CYCLE) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("decompress_with_sampled_low_bits verification failed");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int  before_n;
    int  new_n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = dslb_pkg::OP_LOAD;
    loaded_n      = 0;
    finished_n    = 0;
    mismatch_cnt  = 0;
    results_seen  = 0;
    burst_left    = 0;
    predicted_n   = 0;

    // Directed table
    add_row(dslb_pkg::OP_SAMPLE, 0, '0, 1'b0, 0);             // sampling before any load
    add_row(dslb_pkg::OP_LOAD, 0, '0, 1'b0, 0);               // decompresses to 0
    add_row(dslb_pkg::OP_LOAD, 511, '0, 1'b0, 0);             // decompresses to 3322
    add_row(dslb_pkg::OP_LOAD, 256, '0, 1'b0, 0);             // midpoint value
    add_row(dslb_pkg::OP_LOAD, 256, '0, 1'b0, 0);
    add_row(dslb_pkg::OP_LOAD, 1, '0, 1'b0, 0);               // decompresses to 7
    add_row(dslb_pkg::OP_SAMPLE, 0, pack_cands(20, 31, 31, 31, 31, 31, 31, 31), 1'b1, -10);
    add_row(dslb_pkg::OP_SAMPLE, 0, pack_cands(31, 31, 31, 31, 31, 31, 31, 0), 1'b1, 3332);
    add_row(dslb_pkg::OP_SAMPLE, 0, pack_cands(21, 31, 31, 31, 31, 31, 31, 31), 1'b1, 1655);
    add_row(dslb_pkg::OP_SAMPLE, 0, pack_cands(22, 23, 31, 31, 31, 31, 31, 0), 1'b1, 1676);
    add_row(dslb_pkg::OP_SAMPLE, 0, pack_cands(21, 11, 31, 31, 31, 31, 31, 31), 1'b1, 6);
    add_row(dslb_pkg::OP_SAMPLE, 0, pack_cands(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 0);  // caught up
    add_row(dslb_pkg::OP_LOAD, 255, '0, 1'b0, 0);
    add_row(dslb_pkg::OP_LOAD, 257, '0, 1'b0, 0);
    add_row(dslb_pkg::OP_LOAD, 128, '0, 1'b0, 0);
    add_row(dslb_pkg::OP_LOAD, 384, '0, 1'b0, 0);
    add_row(dslb_pkg::OP_LOAD, 510, '0, 1'b0, 0);
    add_row(dslb_pkg::OP_LOAD, 256, '0, 1'b0, 0);
    add_row(dslb_pkg::OP_SAMPLE, 0, pack_cands(0, 1, 10, 11, 20, 21, 22, 31), 1'b0, 0);
    add_row(dslb_pkg::OP_SAMPLE, 0, {dslb_pkg::CHUNK_W{1'b1}}, 1'b0, 0);  // all rejected
    add_row(dslb_pkg::OP_SAMPLE, 0, pack_cands(21, 21, 5, 15, 31, 30, 9, 2), 1'b0, 0);

    // Hold reset, then release it away from the clock edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table; known rows fix the first coefficient they yield
    foreach (dir_rows[i]) begin
      before_n = predicted_n;
      send_item(dir_rows[i].op, dir_rows[i].t, dir_rows[i].chunk);
      new_n = predicted_n - before_n;
      if (dir_rows[i].known) begin
        if (new_n > 0) begin
          pending_coeffs[pending_coeffs.size() - new_n].coef =
            dslb_pkg::COEF_W'(dir_rows[i].coef);
        end else begin
          mismatch_cnt++;
          $display("%0t: row %0d expected coefficient %0d actual none", $time, i,
                   dir_rows[i].coef);
        end
      end
    end

    // Fill the polynomial with sampling trailing the loads, then finish it
    while (loaded_n < COEFFS) begin
      if ($urandom_range(0, 99) < 80) begin
        send_item(dslb_pkg::OP_LOAD, rand_t(), rand_chunk());
      end else begin
        send_item(dslb_pkg::OP_SAMPLE, dslb_pkg::T_W'($urandom), rand_chunk());
      end
    end
    while (finished_n < COEFFS) begin
      send_item(dslb_pkg::OP_SAMPLE, dslb_pkg::T_W'($urandom), rand_chunk());
    end
    // polynomial finished: these candidates are dropped
    repeat (3) send_item(dslb_pkg::OP_SAMPLE, dslb_pkg::T_W'($urandom), rand_chunk());

    // A load into the full polynomial starts a new one
    send_item(dslb_pkg::OP_LOAD, rand_t(), rand_chunk());

    // Noise: any opcode, any field content
    repeat (20) send_item(1'($urandom_range(0, 1)), dslb_pkg::T_W'($urandom), rand_chunk());
    s_axis_tvalid = 1'b0;

    // Drain the expected coefficients, then watch for strays
    while (pending_coeffs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_coeffs.size() == 0) begin
      $display("decompress_with_sampled_low_bits verification clean");
    end else begin
      $display("decompress_with_sampled_low_bits verification failed");
    end
    $finish;
  end

endmodule
